// ===== rtl/hfa_pkg.sv =====
// hfa_pkg: shared constants, codes and handshake types for the hole-fit allocator
// used by hfa_ctrl, hfa_datapath and hole_fit_allocator
package hfa_pkg;

  // default table geometry
  localparam int NumHolesDef = 16;
  localparam int SizeBitsDef = 16;

  // fixed field widths on the ports
  localparam int IdxW       = 4;
  localparam int FieldSizeW = 16;
  localparam int CfgDataW   = 5;
  localparam int CfgIdxW    = 1;
  localparam int TdataW     = 24;

  // item kinds carried in tuser
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_FIT_MODE   = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_HOLE_COUNT = 1'b1;

  // fit policies
  localparam logic FIT_FIRST = 1'b0;
  localparam logic FIT_BEST  = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load;    // write one hole from the input transfer
    logic start;   // capture request size, clear search state
    logic scan;    // issue one table read and advance
    logic commit;  // write back chosen hole and load result
  } hfa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;  // current read address is the last hole in use
    logic empty;      // no holes in use
    logic out_busy;   // result register still holds an untaken result
  } hfa_sts_t;

endpackage

// ===== rtl/hfa_ram.sv =====
// hfa_ram: generic single write port, single read port RAM with registered read
// no dependencies
module hfa_ram #(
  parameter int Width = 17,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/hfa_ctrl.sv =====
// hfa_ctrl: sequencing state machine of the hole-fit allocator
// depends on hfa_pkg; drives hfa_datapath through hfa_cmd_t
module hfa_ctrl
  import hfa_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_op_i,
  output logic     in_ready_o,
  input  hfa_sts_t sts_i,
  output hfa_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_op_i == OP_LOAD) begin
            cmd_o.load = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            state_d = sts_i.empty ? ST_COMMIT : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      // last read word is judged in this cycle
      ST_DRAIN: begin
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (!sts_i.out_busy) begin
          cmd_o.commit = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/hfa_datapath.sv =====
// hfa_datapath: hole table, fit search registers, configuration and result register
// depends on hfa_pkg and hfa_ram; steered by hfa_ctrl
module hfa_datapath
  import hfa_pkg::*;
#(
  parameter int NumHoles = NumHolesDef,
  parameter int SizeBits = SizeBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  hfa_cmd_t              cmd_i,
  output hfa_sts_t              sts_o,
  input  logic [IdxW-1:0]       in_idx_i,
  input  logic [FieldSizeW-1:0] in_size_i,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_index_i,
  input  logic [CfgDataW-1:0]   cfg_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  out_granted_o,
  output logic [IdxW-1:0]       out_hole_o,
  output logic [FieldSizeW-1:0] out_rem_o
);

  localparam int AddrW = (NumHoles > 1) ? $clog2(NumHoles) : 1;
  localparam int LimW  = $clog2(NumHoles + 1);

  // configuration
  logic            fit_mode_q;
  logic [CfgDataW-1:0] hole_count_q;
  logic [LimW-1:0] limit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_mode_q   <= FIT_FIRST;
      hole_count_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_FIT_MODE:   fit_mode_q   <= cfg_data_i[0];
        REG_HOLE_COUNT: hole_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign limit = (32'(hole_count_q) < NumHoles) ? LimW'(hole_count_q) : LimW'(NumHoles);

  // table: {taken, size}
  logic                  ram_we;
  logic [AddrW-1:0]      ram_waddr;
  logic [SizeBits:0]     ram_wdata;
  logic [SizeBits:0]     ram_rdata;
  logic [LimW-1:0]       cnt_q;
  logic [SizeBits-1:0]   req_q;
  logic                  rd_vld_q;
  logic [AddrW-1:0]      rd_idx_q;
  logic                  found_q;
  logic [AddrW-1:0]      best_idx_q;
  logic [SizeBits-1:0]   best_size_q;
  logic [SizeBits-1:0]   left;
  logic                  load_in_range;
  logic                  fits;
  logic                  take;

  assign load_in_range = 32'(in_idx_i) < NumHoles;
  assign left          = best_size_q - req_q;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AddrW'(in_idx_i);
    ram_wdata = {1'b0, SizeBits'(in_size_i)};
    if (cmd_i.commit) begin
      ram_we    = found_q;
      ram_waddr = best_idx_q;
      ram_wdata = {1'b1, left};
    end else if (cmd_i.load) begin
      ram_we = load_in_range;
    end
  end

  hfa_ram #(
    .Width (SizeBits + 1),
    .Depth (NumHoles)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.scan),
    .raddr_i (cnt_q[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  // candidate check on the word read last cycle
  assign fits = !ram_rdata[SizeBits] && (ram_rdata[SizeBits-1:0] >= req_q);
  assign take = rd_vld_q && fits &&
                (!found_q || (fit_mode_q == FIT_BEST && ram_rdata[SizeBits-1:0] < best_size_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
      found_q  <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan;
      if (cmd_i.start) begin
        cnt_q   <= '0;
        found_q <= 1'b0;
      end else begin
        if (cmd_i.scan) begin
          cnt_q <= cnt_q + LimW'(1);
        end
        if (cmd_i.commit) begin
          found_q <= 1'b0;
        end else if (take) begin
          found_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      req_q <= SizeBits'(in_size_i);
    end
    if (cmd_i.scan) begin
      rd_idx_q <= cnt_q[AddrW-1:0];
    end
    if (take) begin
      best_idx_q  <= rd_idx_q;
      best_size_q <= ram_rdata[SizeBits-1:0];
    end
  end

  // result register
  logic                  out_vld_q;
  logic                  out_granted_q;
  logic [IdxW-1:0]       out_hole_q;
  logic [FieldSizeW-1:0] out_rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_granted_q <= found_q;
      out_hole_q    <= found_q ? IdxW'(best_idx_q) : '0;
      out_rem_q     <= found_q ? FieldSizeW'(left) : '0;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign out_granted_o = out_granted_q;
  assign out_hole_o    = out_hole_q;
  assign out_rem_o     = out_rem_q;

  assign sts_o.scan_last = (cnt_q == limit - LimW'(1));
  assign sts_o.empty     = (limit == '0);
  assign sts_o.out_busy  = out_vld_q && !out_ready_i;

  // a judged read word always follows a scan step
  a_read_follows_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> $past(cmd_i.scan))
    else $error("table read data judged without a scan step");

  // the commit never overwrites a result still waiting
  a_commit_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> !(out_vld_q && !out_ready_i))
    else $error("result overwritten before transfer");

  // a held candidate lies inside the scanned range
  a_pick_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> (LimW'(best_idx_q) < limit))
    else $error("chosen hole outside holes in use");

  // a refused request reports zero hole and size
  a_refusal_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.commit) && !out_granted_q |-> out_hole_q == '0 && out_rem_q == '0)
    else $error("refused request carries a hole or size");

endmodule

// ===== rtl/hole_fit_allocator.sv =====
// hole_fit_allocator: top level of the first-fit / best-fit hole allocator
// depends on hfa_pkg, hfa_ctrl, hfa_datapath (and hfa_ram below it)

// A table of holes, each a size and a taken flag, held in a single-port-read RAM.
// A load transfer (tuser op = load) writes one hole's size and frees it; loads to
// an index beyond the table are dropped and give no result. A request transfer
// walks holes 0 .. min(hole_count, NUM_HOLES)-1, one RAM read per cycle, keeping
// the first fitting free hole (fit_mode 0) or the smallest one with ties to the
// lower index (fit_mode 1), then writes the hole back as taken with the request
// subtracted and presents one result. The result sits in an output register so
// the next item is taken while it waits. Holes must be loaded before a request
// scans them. Configuration must be written only while idle; the block itself
// does not enforce this.
module hole_fit_allocator
  import hfa_pkg::*;
#(
  parameter int NUM_HOLES = NumHolesDef,
  parameter int SIZE_BITS = SizeBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [TdataW-1:0]   s_axis_tdata,   // [3:0] hole_index, [19:4] size_value
  input  logic                s_axis_tuser,   // [0] op
  // result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [TdataW-1:0]   m_axis_tdata,   // [3:0] chosen_hole, [19:4] remaining_size
  output logic                m_axis_tuser,   // [0] granted
  // configuration writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  hfa_cmd_t              cmd;
  hfa_sts_t              sts;
  logic [IdxW-1:0]       out_hole;
  logic [FieldSizeW-1:0] out_rem;

  assign cfg_ready_o = 1'b1;

  hfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hfa_datapath #(
    .NumHoles (NUM_HOLES),
    .SizeBits (SIZE_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_idx_i      (s_axis_tdata[IdxW-1:0]),
    .in_size_i     (s_axis_tdata[IdxW+FieldSizeW-1:IdxW]),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_granted_o (m_axis_tuser),
    .out_hole_o    (out_hole),
    .out_rem_o     (out_rem)
  );

  assign m_axis_tdata = {(TdataW - IdxW - FieldSizeW)'(0), out_rem, out_hole};

endmodule

// ===== dv/testbench.sv =====
// testbench: self-checking bench for hole_fit_allocator, first-fit and best-fit placement
// builds its own model of the hole table and checks every result transfer against it
// depends on hfa_pkg and the hole_fit_allocator rtl
module testbench;
  import hfa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT    = 1_000_000;
  localparam int          SETTLE_CYCLES  = 24;   // a full 16-hole scan plus margin
  localparam int          HOLD_OFF_LEN   = 400;

  typedef struct packed {
    logic                  granted;
    logic [IdxW-1:0]       hole;
    logic [FieldSizeW-1:0] left;
  } grant_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [TdataW-1:0]   s_axis_tdata = '0;   // [3:0] hole_index, [19:4] size_value
  logic                s_axis_tuser = 1'b0; // [0] op
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [TdataW-1:0]   m_axis_tdata;        // [3:0] chosen_hole, [19:4] remaining_size
  logic                m_axis_tuser;        // [0] granted
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  hole_fit_allocator u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // model of the hole table and its registers
  logic [FieldSizeW-1:0] tbl_size  [NumHolesDef];
  logic                  tbl_taken [NumHolesDef];
  logic                  fit_sel    = FIT_FIRST;
  logic [CfgDataW-1:0]   scan_limit = '0;
  grant_t                pending_grants [$];

  int unsigned fault_count  = 0;
  int unsigned cycle_count  = 0;
  int          idle_rate    = 0;   // 1-in-n chance of a burst of idling, 0 for none
  bit          hold_off_req = 1'b0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  function automatic grant_t place_request(input logic [FieldSizeW-1:0] want);
    grant_t g;
    int     span;
    int     pick;
    bit     found;
    g     = '0;
    pick  = 0;
    found = 1'b0;
    span  = (scan_limit > NumHolesDef) ? NumHolesDef : int'(scan_limit);
    for (int k = 0; k < span; k++) begin
      if (!tbl_taken[k] && tbl_size[k] >= want) begin
        if (!found) begin
          pick  = k;
          found = 1'b1;
          if (fit_sel == FIT_FIRST) break;
        end else if (tbl_size[k] < tbl_size[pick]) begin
          pick = k;
        end
      end
    end
    if (found) begin
      tbl_taken[pick] = 1'b1;
      tbl_size[pick]  = tbl_size[pick] - want;
      g.granted = 1'b1;
      g.hole    = IdxW'(pick);
      g.left    = tbl_size[pick];
    end
    return g;
  endfunction

  // handshakes are sampled at the falling edge, where everything has settled
  task automatic send_item(input logic op, input logic [IdxW-1:0] idx,
                           input logic [FieldSizeW-1:0] sz);
    bit ok;
    if (idle_rate != 0 && $urandom_range(1, idle_rate) == 1) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= TdataW'({sz, idx});
    forever begin
      @(negedge clk_i);
      ok = s_axis_tready;
      @(posedge clk_i);
      if (ok) break;
    end
    if (op == OP_LOAD) begin
      tbl_size[idx]  = sz;
      tbl_taken[idx] = 1'b0;
    end else begin
      pending_grants.push_back(place_request(sz));
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    bit ok;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    forever begin
      @(negedge clk_i);
      ok = cfg_ready_o;
      @(posedge clk_i);
      if (ok) break;
    end
    if (idx == REG_FIT_MODE) fit_sel = val[0];
    else scan_limit = val;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // loads give no result, so the bench waits SETTLE_CYCLES more after the last one comes back
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_grants.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic reconfigure(input logic mode, input logic [CfgDataW-1:0] count);
    drain();
    write_reg(REG_FIT_MODE, CfgDataW'(mode));
    write_reg(REG_HOLE_COUNT, count);
  endtask

  task automatic run_traffic(input int items, input int rate);
    logic [FieldSizeW-1:0] sz;
    logic                  op;
    idle_rate = rate;
    for (int n = 0; n < items; n++) begin
      op = ($urandom_range(0, 99) < 35) ? OP_LOAD : OP_REQUEST;
      if (op == OP_LOAD) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: sz = FieldSizeW'($urandom_range(0, 16'hFFFF));
          6, 7:             sz = tbl_size[$urandom_range(0, NumHolesDef - 1)];  // ties
          8:                sz = FieldSizeW'($urandom_range(0, 15));
          default:          sz = $urandom_range(0, 1) ? '1 : '0;
        endcase
      end else begin
        case ($urandom_range(0, 9))
          0, 1:       sz = FieldSizeW'($urandom_range(0, 16'hFFFF));
          2, 3, 4, 5: sz = FieldSizeW'($urandom_range(0, 1023));
          6, 7:       sz = tbl_size[$urandom_range(0, NumHolesDef - 1)];  // exact fit
          8:          sz = '0;
          default:    sz = '1;
        endcase
      end
      send_item(op, IdxW'($urandom_range(0, NumHolesDef - 1)), sz);
    end
  endtask

  // every hole gets written here, so no later scan reads an unwritten entry
  task automatic test_table_load;
    logic [FieldSizeW-1:0] sz;
    reconfigure(FIT_FIRST, CfgDataW'(NumHolesDef));
    for (int k = 0; k < NumHolesDef; k++) begin
      case (k)
        0:       sz = 16'h0010;
        1:       sz = 16'hFFFF;
        2:       sz = 16'h0000;
        3:       sz = 16'h0100;
        4, 5:    sz = 16'h0040;
        6:       sz = 16'h8000;
        7:       sz = 16'h5555;
        8:       sz = 16'hAAAA;
        default: sz = 16'h1000 + FieldSizeW'(k) * 16'h0111;
      endcase
      send_item(OP_LOAD, IdxW'(k), sz);
    end
  endtask

  task automatic test_first_fit;
    send_item(OP_REQUEST, 4'hF, 16'h0000);
    send_item(OP_REQUEST, 4'h0, 16'hFFFF);
    send_item(OP_REQUEST, 4'h3, 16'hFFFF);   // nothing left that large
  endtask

  task automatic test_best_fit;
    reconfigure(FIT_BEST, CfgDataW'(NumHolesDef));
    send_item(OP_LOAD, 4'd5, 16'h0040);
    send_item(OP_REQUEST, 4'h0, 16'h0040);   // equal holes, lower index wins
    send_item(OP_REQUEST, 4'h0, 16'h0003);
  endtask

  task automatic test_hole_count_edges;
    reconfigure(FIT_FIRST, '0);
    send_item(OP_REQUEST, 4'h0, 16'h0005);
    reconfigure(FIT_BEST, '1);               // above the table size
    send_item(OP_REQUEST, 4'h0, 16'h0001);
    reconfigure(FIT_FIRST, CfgDataW'(1));
    send_item(OP_LOAD, 4'd0, 16'h0007);
    send_item(OP_REQUEST, 4'h0, 16'h0008);
    send_item(OP_REQUEST, 4'h0, 16'h0007);
  endtask

  task automatic test_random_mix;
    logic [CfgDataW-1:0] count;
    int                  rate;
    for (int p = 0; p < 7; p++) begin
      case (p)
        0, 1:    count = CfgDataW'(NumHolesDef);
        2:       count = CfgDataW'($urandom_range(NumHolesDef + 1, 31));
        3:       count = CfgDataW'(1);
        4:       count = CfgDataW'($urandom_range(2, NumHolesDef - 1));
        5:       count = CfgDataW'(NumHolesDef);
        default: count = '0;
      endcase
      case (p)
        2:       rate = 0;
        1, 4:    rate = 3;
        default: rate = 6;
      endcase
      reconfigure((p % 2) ? FIT_BEST : FIT_FIRST, count);
      run_traffic((p == 6) ? 60 : 240, rate);
    end
  endtask

  task automatic test_output_backpressure;
    reconfigure(FIT_BEST, CfgDataW'(NumHolesDef));
    idle_rate    = 0;
    hold_off_req = 1'b1;
    run_traffic(250, 0);
  endtask

  task automatic test_steady_stream;
    reconfigure(FIT_FIRST, CfgDataW'(NumHolesDef));
    run_traffic(150, 0);
  endtask

  // result side ready, with random stalls and one long hold-off on request
  initial begin : result_sink
    int stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall = HOLD_OFF_LEN;
      end else if (stall == 0 && idle_rate != 0 && $urandom_range(1, 2 * idle_rate) == 1) begin
        stall = $urandom_range(1, 18);
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : result_check
    grant_t got;
    grant_t want;
    forever begin
      @(negedge clk_i);
      if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
        got.granted = m_axis_tuser;
        got.hole    = m_axis_tdata[IdxW-1:0];
        got.left    = m_axis_tdata[IdxW+FieldSizeW-1:IdxW];
        if (pending_grants.size() == 0) begin
          if (fault_count < 10)
            $display("%0t: result transfer with none expected: granted %0b hole %0d left %h",
                     $realtime, got.granted, got.hole, got.left);
          fault_count++;
        end else begin
          want = pending_grants.pop_front();
          if (got.granted !== want.granted || got.hole !== want.hole ||
              got.left !== want.left) begin
            if (fault_count < 10)
              $display("%0t: mismatch: granted %0b/%0b hole %0d/%0d left %h/%h (exp/act)",
                       $realtime, want.granted, got.granted, want.hole, got.hole,
                       want.left, got.left);
            fault_count++;
          end
        end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_table_load();
    test_first_fit();
    test_best_fit();
    test_hole_count_edges();
    test_random_mix();
    test_output_backpressure();
    test_steady_stream();
    drain();
    if (fault_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
